// ===== rtl/core/bhq_pkg.sv =====
// Shared constants and codes for the binary min-heap queue.
package bhq_pkg;

    localparam int DEF_CAPACITY  = 1024;
    localparam int DEF_KEY_WIDTH = 32;
    localparam int DEF_TAG_WIDTH = 16;

    localparam int IN_KEY_W    = 32;
    localparam int IN_TAG_W    = 16;
    localparam int OUT_COUNT_W = 11;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } op_status_t;

endpackage

// ===== rtl/core/binary_min_heap_queue.sv =====
// Binary min-heap priority queue top level: sequencer and entry memory.
// An insert moves a hole up from the end, shifting each larger parent down, then writes the entry.
// A remove that empties the queue only reads the root and the last entry; otherwise the last entry
// sinks from the root, one level per child compare. The single read port paces both operations.
// The next transaction can be accepted once the result is registered, which may wait for m_ready.
// Reset clears the entry count and the output valid flag; memory contents stay undefined.
module binary_min_heap_queue
    import bhq_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH,
    parameter int TAG_WIDTH = DEF_TAG_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_req_type,
    input  logic [IN_KEY_W-1:0]    s_item_key,
    input  logic [IN_TAG_W-1:0]    s_item_tag,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [IN_KEY_W-1:0]    m_popped_key,
    output logic [IN_TAG_W-1:0]    m_popped_tag,
    output logic [1:0]             m_op_status,
    output logic                   m_heap_empty,
    output logic [OUT_COUNT_W-1:0] m_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int EW = KEY_WIDTH + TAG_WIDTH;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    bhq_ctrl #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .TAG_WIDTH (TAG_WIDTH),
        .AW        (AW),
        .EW        (EW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_item_key    (s_item_key),
        .s_item_tag    (s_item_tag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_popped_key  (m_popped_key),
        .m_popped_tag  (m_popped_tag),
        .m_op_status   (m_op_status),
        .m_heap_empty  (m_heap_empty),
        .m_entry_count (m_entry_count),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    bhq_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (EW),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ===== rtl/core/bhq_mem.sv =====
// Heap entry storage: one write port and one read port with registered read data.
module bhq_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bhq_ctrl.sv =====
// Sequencer for heap insert and remove, with the result output register.
module bhq_ctrl
    import bhq_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH,
    parameter int TAG_WIDTH = DEF_TAG_WIDTH,
    parameter int AW        = $clog2(CAPACITY),
    parameter int EW        = KEY_WIDTH + TAG_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_req_type,
    input  logic [IN_KEY_W-1:0]    s_item_key,
    input  logic [IN_TAG_W-1:0]    s_item_tag,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [IN_KEY_W-1:0]    m_popped_key,
    output logic [IN_TAG_W-1:0]    m_popped_tag,
    output logic [1:0]             m_op_status,
    output logic                   m_heap_empty,
    output logic [OUT_COUNT_W-1:0] m_entry_count,
    output logic                   mem_we,
    output logic [AW-1:0]          mem_waddr,
    output logic [EW-1:0]          mem_wdata,
    output logic [AW-1:0]          mem_raddr,
    input  logic [EW-1:0]          mem_rdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_POP_ROOT,
        S_POP_LAST,
        S_POP_MOVE,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         hole_reg, hole_next;
    logic [KEY_WIDTH-1:0]  key_reg, key_next;
    logic [TAG_WIDTH-1:0]  tag_reg, tag_next;
    logic [KEY_WIDTH-1:0]  lkey_reg, lkey_next;
    logic [TAG_WIDTH-1:0]  ltag_reg, ltag_next;
    logic [KEY_WIDTH-1:0]  pkey_reg, pkey_next;
    logic [TAG_WIDTH-1:0]  ptag_reg, ptag_next;
    op_status_t            status_reg, status_next;

    logic                   out_valid_reg, out_valid_next;
    logic [IN_KEY_W-1:0]    out_key_reg, out_key_next;
    logic [IN_TAG_W-1:0]    out_tag_reg, out_tag_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic                   out_empty_reg, out_empty_next;
    logic [OUT_COUNT_W-1:0] out_count_reg, out_count_next;

    logic [KEY_WIDTH+IN_KEY_W-1:0]  in_key_ext;
    logic [TAG_WIDTH+IN_TAG_W-1:0]  in_tag_ext;
    logic [KEY_WIDTH+IN_KEY_W-1:0]  pop_key_ext;
    logic [TAG_WIDTH+IN_TAG_W-1:0]  pop_tag_ext;
    logic [CW+OUT_COUNT_W-1:0]      count_ext;

    logic [KEY_WIDTH-1:0] rd_key;
    logic [TAG_WIDTH-1:0] rd_tag;
    logic [PW-1:0]        hole_w;
    logic [PW-1:0]        count_w;
    logic [PW-1:0]        left_pos;
    logic [PW-1:0]        child_pos;
    logic [PW-1:0]        grand_pos;
    logic [PW-1:0]        last_addr;
    logic [KEY_WIDTH-1:0] ckey;
    logic [TAG_WIDTH-1:0] ctag;
    logic                 sel_right;
    logic                 accept;

    assign in_key_ext  = {{KEY_WIDTH{1'b0}}, s_item_key};
    assign in_tag_ext  = {{TAG_WIDTH{1'b0}}, s_item_tag};
    assign pop_key_ext = {{IN_KEY_W{pkey_reg[KEY_WIDTH-1]}}, pkey_reg};
    assign pop_tag_ext = {{IN_TAG_W{1'b0}}, ptag_reg};
    assign count_ext   = {{OUT_COUNT_W{1'b0}}, count_reg};

    assign rd_key    = mem_rdata[EW-1:TAG_WIDTH];
    assign rd_tag    = mem_rdata[TAG_WIDTH-1:0];
    assign hole_w    = {1'b0, hole_reg};
    assign count_w   = {1'b0, count_reg};
    assign left_pos  = {hole_reg, 1'b0};
    assign last_addr = count_w - PW'(1);

    assign sel_right = (state_reg == S_DN_R) && ($signed(rd_key) < $signed(lkey_reg));
    assign child_pos = sel_right ? (left_pos + PW'(1)) : left_pos;
    assign grand_pos = {child_pos[PW-2:0], 1'b0};
    assign ckey      = (state_reg == S_DN_R && !sel_right) ? lkey_reg : rd_key;
    assign ctag      = (state_reg == S_DN_R && !sel_right) ? ltag_reg : rd_tag;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        hole_next   = hole_reg;
        key_next    = key_reg;
        tag_next    = tag_reg;
        lkey_next   = lkey_reg;
        ltag_next   = ltag_reg;
        pkey_next   = pkey_reg;
        ptag_next   = ptag_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = {key_reg, tag_reg};
        mem_raddr   = '0;

        out_valid_next  = out_valid_reg && !m_ready;
        out_key_next    = out_key_reg;
        out_tag_next    = out_tag_reg;
        out_status_next = out_status_reg;
        out_empty_next  = out_empty_reg;
        out_count_next  = out_count_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    pkey_next   = '0;
                    ptag_next   = '0;
                    status_next = ST_OK;
                    key_next    = in_key_ext[KEY_WIDTH-1:0];
                    tag_next    = in_tag_ext[TAG_WIDTH-1:0];
                    if (s_req_type == REQ_INSERT) begin
                        if (count_reg == CW'(CAPACITY)) begin
                            status_next = ST_OVERFLOW;
                            state_next  = S_DONE;
                        end else begin
                            hole_next  = count_reg + CW'(1);
                            state_next = S_UP;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            status_next = ST_UNDERFLOW;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_POP_ROOT;
                        end
                    end
                end
            end
            S_UP: begin
                if (hole_reg == CW'(1)) begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end else begin
                    mem_raddr  = AW'((hole_w >> 1) - PW'(1));
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_waddr = AW'(hole_w - PW'(1));
                mem_we    = 1'b1;
                if ($signed(key_reg) < $signed(rd_key)) begin
                    mem_wdata = mem_rdata;
                    hole_next = hole_reg >> 1;
                    if ((hole_reg >> 1) > CW'(1)) begin
                        mem_raddr = AW'((hole_w >> 2) - PW'(1));
                    end else begin
                        state_next = S_UP;
                    end
                end else begin
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
            end
            S_POP_ROOT: begin
                mem_raddr  = '0;
                state_next = S_POP_LAST;
            end
            S_POP_LAST: begin
                pkey_next  = rd_key;
                ptag_next  = rd_tag;
                mem_raddr  = AW'(last_addr);
                state_next = S_POP_MOVE;
            end
            S_POP_MOVE: begin
                key_next   = rd_key;
                tag_next   = rd_tag;
                count_next = count_reg - CW'(1);
                hole_next  = CW'(1);
                if (count_reg == CW'(1)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_DN;
                end
            end
            S_DN: begin
                if (left_pos > count_w) begin
                    mem_we     = 1'b1;
                    mem_waddr  = AW'(hole_w - PW'(1));
                    state_next = S_DONE;
                end else begin
                    mem_raddr  = AW'(left_pos - PW'(1));
                    state_next = S_DN_L;
                end
            end
            S_DN_L, S_DN_R: begin
                lkey_next = rd_key;
                ltag_next = rd_tag;
                if (state_reg == S_DN_L && left_pos < count_w) begin
                    mem_raddr  = AW'(left_pos);
                    state_next = S_DN_R;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(hole_w - PW'(1));
                    if ($signed(ckey) < $signed(key_reg)) begin
                        mem_wdata = {ckey, ctag};
                        hole_next = CW'(child_pos);
                        if (grand_pos <= count_w) begin
                            mem_raddr  = AW'(grand_pos - PW'(1));
                            state_next = S_DN_L;
                        end else begin
                            state_next = S_DN;
                        end
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next  = 1'b1;
                    out_key_next    = pop_key_ext[IN_KEY_W-1:0];
                    out_tag_next    = pop_tag_ext[IN_TAG_W-1:0];
                    out_status_next = status_reg;
                    out_empty_next  = (count_reg == '0);
                    out_count_next  = count_ext[OUT_COUNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        hole_reg       <= hole_next;
        key_reg        <= key_next;
        tag_reg        <= tag_next;
        lkey_reg       <= lkey_next;
        ltag_reg       <= ltag_next;
        pkey_reg       <= pkey_next;
        ptag_reg       <= ptag_next;
        status_reg     <= status_next;
        out_key_reg    <= out_key_next;
        out_tag_reg    <= out_tag_next;
        out_status_reg <= out_status_next;
        out_empty_reg  <= out_empty_next;
        out_count_reg  <= out_count_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_popped_key  = out_key_reg;
    assign m_popped_tag  = out_tag_reg;
    assign m_op_status   = out_status_reg;
    assign m_heap_empty  = out_empty_reg;
    assign m_entry_count = out_count_reg;

endmodule
